### hdl/calendar_to_tick_count_core_macros.svh
// Assertion macros for the calendar to tick count core.
`ifndef CALENDAR_TO_TICK_COUNT_CORE_MACROS_SVH
`define CALENDAR_TO_TICK_COUNT_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, ignored while in reset.
`define CTTC_ASSERT_IMPLY(label, clock, reset_n, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");
// Implication after a fixed number of cycles, ignored while in reset.
`define CTTC_ASSERT_LATENCY(label, clock, reset_n, ante, cycles, cons) \
    label: assert property (@(posedge clock) disable iff (!reset_n) \
        (ante) |-> ##cycles (cons)) \
        else $error("%m: latency check failed");
`else
`define CTTC_ASSERT_IMPLY(label, clock, reset_n, ante, cons)
`define CTTC_ASSERT_LATENCY(label, clock, reset_n, ante, cycles, cons)
`endif

`endif

### hdl/cttc_pkg.sv
// Types, constants and tables shared by the calendar to tick count core.
package cttc_pkg;

    localparam int YEAR_W  = 14;
    localparam int NS10_W  = 29;
    localparam int DAYS_W  = 25;
    localparam int SECS_W  = 17;
    localparam int TOTAL_W = 40;
    localparam int TICKS_W = 64;

    // Reciprocal for y / 100 on 14-bit years: (y * 5243) >> 19.
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    // Reciprocal for ns / 10 on 32-bit values: (ns * 0xCCCCCCCD) >> 35.
    localparam logic [31:0] DIV10_MUL    = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT  = 35;

    localparam logic [8:0]  DAYS_PER_YEAR   = 9'd365;
    localparam logic [12:0] MONTH_DAY_MUL   = 13'd7826;
    localparam logic [8:0]  DAY_OFFSET      = 9'd397;
    localparam logic [16:0] SECS_PER_DAY    = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR   = 12'd3600;
    localparam logic [5:0]  SECS_PER_MINUTE = 6'd60;
    localparam logic [26:0] TICKS_PER_SEC   = 27'd100000000;
    localparam logic [31:0] NS_LIMIT        = 32'd1000000000;
    localparam logic [6:0]  CENTURY         = 7'd100;
    localparam logic [8:0]  QUAD_CENTURY    = 9'd400;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    localparam logic [3:0] MONTH_JAN = 4'd0;
    localparam logic [3:0] MONTH_FEB = 4'd1;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [7:0]        month;
        logic [7:0]        day_of_month;
        logic [7:0]        hour;
        logic [7:0]        minute;
        logic [7:0]        second;
        logic [31:0]       nanoseconds;
    } cttc_in_t;

    typedef struct packed {
        logic [TICKS_W-1:0] ticks;
        logic               status;
    } cttc_out_t;

    // Handoff from the calendar stages to the scaling stages.
    typedef struct packed {
        logic                     valid;
        logic                     ok;
        logic signed [DAYS_W-1:0] days;
        logic [SECS_W-1:0]        secs;
        logic [NS10_W-1:0]        ns10;
    } cttc_mid_t;

    // Last valid zero-based day of each zero-based month, February in common years.
    function automatic logic [4:0] last_day(input logic [3:0] m0);
        logic [4:0] d;
        d = 5'd0;
        case (m0)
            4'd0:    d = 5'd30;
            4'd1:    d = 5'd27;
            4'd2:    d = 5'd30;
            4'd3:    d = 5'd29;
            4'd4:    d = 5'd30;
            4'd5:    d = 5'd29;
            4'd6:    d = 5'd30;
            4'd7:    d = 5'd30;
            4'd8:    d = 5'd29;
            4'd9:    d = 5'd30;
            4'd10:   d = 5'd29;
            4'd11:   d = 5'd30;
            default: d = 5'd0;
        endcase
        return d;
    endfunction

endpackage

### hdl/cttc_calendar.sv
// Field checks, leap year and day/second counts: two pipeline stages.
module cttc_calendar (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  cttc_pkg::cttc_in_t item,
    output cttc_pkg::cttc_mid_t mid
);
    import cttc_pkg::*;

    // Stage 1 registers
    logic              s1_valid_reg;
    logic              s1_ok_reg;
    logic [YEAR_W-1:0] s1_year_reg;
    logic [7:0]        s1_q100_reg;
    logic [7:0]        s1_month_reg;
    logic [7:0]        s1_d0_reg;
    logic [4:0]        s1_hour_reg;
    logic [5:0]        s1_minute_reg;
    logic [5:0]        s1_second_reg;
    logic [NS10_W-1:0] s1_ns10_reg;

    logic              s1_ok_next;
    logic [26:0]       q100_prod;
    logic [63:0]       ns10_prod;

    // Stage 2 registers
    logic                     s2_valid_reg;
    logic                     s2_ok_reg;
    logic signed [DAYS_W-1:0] s2_days_reg;
    logic [SECS_W-1:0]        s2_secs_reg;
    logic [NS10_W-1:0]        s2_ns10_reg;

    logic [YEAR_W-1:0] rem100;
    logic [YEAR_W-1:0] rem400;
    logic [5:0]        q400;
    logic              leap;
    logic [3:0]        m0;
    logic              day_ok;
    logic [22:0]       y365;
    logic [16:0]       month_prod;
    logic [1:0]        adj;
    logic [DAYS_W-1:0] days_next;
    logic [SECS_W-1:0] secs_next;

    assign q100_prod = {13'd0, item.year} * {14'd0, DIV100_MUL};
    assign ns10_prod = {32'd0, item.nanoseconds} * {32'd0, DIV10_MUL};

    assign s1_ok_next = (item.month != 8'd0) && (item.month <= 8'd12)
                     && (item.day_of_month != 8'd0)
                     && (item.hour < 8'd24) && (item.minute < 8'd60)
                     && (item.second < 8'd60) && (item.nanoseconds < NS_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ok_reg     <= s1_ok_next;
        s1_year_reg   <= item.year;
        s1_q100_reg   <= q100_prod[DIV100_SHIFT +: 8];
        s1_month_reg  <= item.month;
        s1_d0_reg     <= item.day_of_month - 8'd1;
        s1_hour_reg   <= item.hour[4:0];
        s1_minute_reg <= item.minute[5:0];
        s1_second_reg <= item.second[5:0];
        s1_ns10_reg   <= ns10_prod[DIV10_SHIFT +: NS10_W];
    end

    // Leap year from the reciprocal quotient
    assign q400   = s1_q100_reg[7:2];
    assign rem100 = s1_year_reg - YEAR_W'({6'd0, s1_q100_reg} * {7'd0, CENTURY});
    assign rem400 = s1_year_reg - YEAR_W'({8'd0, q400} * {5'd0, QUAD_CENTURY});
    assign leap   = (s1_year_reg[1:0] == 2'd0) && ((rem100 != '0) || (rem400 == '0));

    assign m0     = s1_month_reg[3:0] - 4'd1;
    assign day_ok = (s1_d0_reg <= {3'd0, last_day(m0)})
                 || ((m0 == MONTH_FEB) && leap && (s1_d0_reg == 8'd28));

    assign y365       = {9'd0, s1_year_reg} * {14'd0, DAYS_PER_YEAR};
    assign month_prod = {13'd0, s1_month_reg[3:0]} * {4'd0, MONTH_DAY_MUL};
    assign adj        = ((m0 == MONTH_JAN) || (m0 == MONTH_FEB)) ? (leap ? 2'd1 : 2'd2) : 2'd0;

    // May go below zero for year zero; two's complement carries it on.
    assign days_next = DAYS_W'(y365) + DAYS_W'(s1_year_reg[YEAR_W-1:2])
                     - DAYS_W'(s1_q100_reg) + DAYS_W'(q400)
                     + DAYS_W'(month_prod[16:8]) + DAYS_W'(s1_d0_reg[4:0])
                     + DAYS_W'(adj) - DAYS_W'(DAY_OFFSET);

    assign secs_next = SECS_W'({12'd0, s1_hour_reg} * {5'd0, SECS_PER_HOUR})
                     + SECS_W'({6'd0, s1_minute_reg} * {6'd0, SECS_PER_MINUTE})
                     + SECS_W'(s1_second_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_ok_reg   <= s1_ok_reg && day_ok;
        s2_days_reg <= $signed(days_next);
        s2_secs_reg <= secs_next;
        s2_ns10_reg <= s1_ns10_reg;
    end

    assign mid.valid = s2_valid_reg;
    assign mid.ok    = s2_ok_reg;
    assign mid.days  = s2_days_reg;
    assign mid.secs  = s2_secs_reg;
    assign mid.ns10  = s2_ns10_reg;

endmodule

### hdl/cttc_scale.sv
// Seconds and tick scaling with split partial products: three pipeline stages.
module cttc_scale (
    input  logic                clk,
    input  logic                rst_n,
    input  cttc_pkg::cttc_mid_t mid,
    output logic                done,
    output cttc_pkg::cttc_out_t result
);
    import cttc_pkg::*;

    localparam int LO_W = 20;
    localparam int HI_W = TOTAL_W - LO_W;

    // Stage 3
    logic                      s3_valid_reg;
    logic                      s3_ok_reg;
    logic signed [TOTAL_W-1:0] s3_total_reg;
    logic [NS10_W-1:0]         s3_ns10_reg;
    logic signed [41:0]        day_secs;
    logic signed [41:0]        total_next;

    // Stage 4
    logic                      s4_valid_reg;
    logic                      s4_ok_reg;
    logic [LO_W+26:0]          s4_plo_reg;
    logic signed [HI_W+27:0]   s4_phi_reg;
    logic [NS10_W-1:0]         s4_ns10_reg;

    // Output
    logic                      done_reg;
    cttc_out_t                 result_reg;
    logic [TICKS_W-1:0]        ticks_next;

    assign day_secs   = 42'(mid.days) * 42'($signed({1'b0, SECS_PER_DAY}));
    assign total_next = day_secs + $signed({25'd0, mid.secs});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= mid.valid;
            s4_valid_reg <= s3_valid_reg;
            done_reg     <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_ok_reg    <= mid.ok;
        s3_total_reg <= total_next[TOTAL_W-1:0];
        s3_ns10_reg  <= mid.ns10;
    end

    always_ff @(posedge clk)
    begin
        s4_ok_reg   <= s3_ok_reg;
        s4_plo_reg  <= {27'd0, s3_total_reg[LO_W-1:0]} * {20'd0, TICKS_PER_SEC};
        s4_phi_reg  <= (HI_W+28)'($signed(s3_total_reg[TOTAL_W-1:LO_W]))
                     * (HI_W+28)'($signed({1'b0, TICKS_PER_SEC}));
        s4_ns10_reg <= s3_ns10_reg;
    end

    // Recombine the halves; the sum wraps modulo 2^64.
    assign ticks_next = (TICKS_W'(s4_phi_reg) << LO_W)
                      + TICKS_W'(s4_plo_reg) + TICKS_W'(s4_ns10_reg);

    always_ff @(posedge clk)
    begin
        result_reg.ticks  <= s4_ok_reg ? ticks_next : '0;
        result_reg.status <= s4_ok_reg ? STATUS_OK : STATUS_RANGE;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### hdl/calendar_to_tick_count_core.sv
// Top level of the calendar to tick count core.
//
//  Channel | Handshake        | Payload            | Direction
//  --------+------------------+--------------------+----------
//  item    | start, busy      | item (cttc_in_t)   | in
//  result  | done (strobe)    | result (cttc_out_t)| out
//
// A transaction is taken at every edge with start high; busy stays low.
// The stages are two calendar stages, seconds scaling, split
// partial products by 1e8, and the final recombining add.
// One result per cycle is sustained; the result is held for one cycle only.
// Reset clears the valid bits of every stage; data registers are not reset.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module calendar_to_tick_count_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  cttc_pkg::cttc_in_t  item,
    output logic                done,
    output cttc_pkg::cttc_out_t result
);
    import cttc_pkg::*;

`include "calendar_to_tick_count_core_macros.svh"

    logic      accept;
    cttc_mid_t mid;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    cttc_calendar u_calendar (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .mid    (mid)
    );

    cttc_scale u_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .mid    (mid),
        .done   (done),
        .result (result)
    );

    `CTTC_ASSERT_LATENCY(a_latency, clk, rst_n, accept, 5, done)
    `CTTC_ASSERT_IMPLY(a_no_orphan, clk, rst_n, done, $past(accept, 5))
    `CTTC_ASSERT_IMPLY(a_err_zero, clk, rst_n, done && (result.status == STATUS_RANGE), result.ticks == 64'd0)

endmodule

### bench/tick_count_checker.sv
// Checker that predicts and compares every tick count result of the core.
`timescale 1ns / 1ps

module tick_count_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  cttc_pkg::cttc_in_t  item,
    input  logic                done,
    input  cttc_pkg::cttc_out_t result,
    output int                  mismatches,
    output int                  outstanding,
    output int                  dates_ok,
    output int                  dates_rejected
);
    import cttc_pkg::*;

    localparam logic [63:0] TICKS_PER_SECOND = 64'd100000000;
    localparam logic [63:0] TICKS_PER_DAY    = 64'd8640000000000;

    cttc_out_t expected_ticks[$];
    cttc_out_t want;

    function automatic cttc_out_t date_to_ticks(input cttc_in_t d);
        logic [63:0] yr;
        logic [63:0] days;
        logic [63:0] secs;
        logic        leap;
        logic        in_range;
        int unsigned month_len;
        cttc_out_t   r;
        yr = 64'(d.year);
        leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        case (d.month)
            8'd2:                    month_len = leap ? 29 : 28;
            8'd4, 8'd6, 8'd9, 8'd11: month_len = 30;
            default:                 month_len = 31;
        endcase
        in_range = d.month >= 8'd1 && d.month <= 8'd12
            && d.day_of_month >= 8'd1 && d.day_of_month <= month_len
            && d.hour < 8'd24 && d.minute < 8'd60 && d.second < 8'd60
            && d.nanoseconds < 32'd1000000000;
        r.status = in_range ? STATUS_OK : STATUS_RANGE;
        r.ticks  = '0;
        if (in_range)
        begin
            // Day number with March as the start of the counting year, then shift to 1 Jan year 1.
            days = yr * 64'd365 + yr / 64'd4 - yr / 64'd100 + yr / 64'd400
                + ((64'(d.month) * 64'd7826) >> 8) + 64'(d.day_of_month) - 64'd1;
            if (d.month <= 8'd2)
                days = days + (leap ? 64'd1 : 64'd2);
            days = days - 64'd397;
            secs = 64'(d.hour) * 64'd3600 + 64'(d.minute) * 64'd60 + 64'(d.second);
            r.ticks = days * TICKS_PER_DAY + secs * TICKS_PER_SECOND
                + 64'(d.nanoseconds / 32'd10);
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            mismatches     = 0;
            outstanding    = 0;
            dates_ok       = 0;
            dates_rejected = 0;
        end
        else
        begin
            if ($isunknown(done))
            begin
                mismatches++;
                $display("%0t: done strobe unknown, expected 0 or 1, got %b", $time, done);
            end
            else if (done)
            begin
                if (expected_ticks.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got ticks=%h status=%b",
                             $time, result.ticks, result.status);
                end
                else
                begin
                    want = expected_ticks.pop_front();
                    if (result.ticks !== want.ticks || result.status !== want.status)
                    begin
                        mismatches++;
                        $display("%0t: expected ticks=%h status=%b, got ticks=%h status=%b",
                                 $time, want.ticks, want.status, result.ticks,
                                 result.status);
                    end
                    if (want.status == STATUS_OK)
                        dates_ok++;
                    else
                        dates_rejected++;
                end
            end
            if (start && !busy)
                expected_ticks.push_back(date_to_ticks(item));
            outstanding = expected_ticks.size();
        end
    end

endmodule

### bench/testbench.sv
// Top of the bench: clock, reset, timestamp stimulus and the final verdict.
`timescale 1ns / 1ps

module testbench;
    import cttc_pkg::*;

    localparam int SETTLE_CYCLES = 10;    // five-stage pipeline, with margin
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_DATES  = 630;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      start;
    logic      busy;
    logic      done;
    cttc_in_t  item;
    cttc_out_t result;

    int mismatches;
    int outstanding;
    int dates_ok;
    int dates_rejected;
    int sent = 0;
    int stall_cycles = 0;
    bit allow_gaps = 1'b1;

    always #5 clk = ~clk;

    calendar_to_tick_count_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    tick_count_checker tick_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .item           (item),
        .done           (done),
        .result         (result),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .dates_ok       (dates_ok),
        .dates_rejected (dates_rejected)
    );

    // End the run if neither side moves a transaction for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("[calendar_to_tick_count_core] ERROR");
                $finish;
            end
        end
    end

    function automatic cttc_in_t stamp(input int unsigned y, input int unsigned mo,
                                       input int unsigned d, input int unsigned h,
                                       input int unsigned mi, input int unsigned s,
                                       input int unsigned ns);
        cttc_in_t t;
        t.year         = y[YEAR_W-1:0];
        t.month        = mo[7:0];
        t.day_of_month = d[7:0];
        t.hour         = h[7:0];
        t.minute       = mi[7:0];
        t.second       = s[7:0];
        t.nanoseconds  = ns;
        return t;
    endfunction

    // Mostly well-formed timestamps; the rest have one field or everything scrambled.
    function automatic cttc_in_t random_date();
        cttc_in_t    t;
        logic [95:0] noise;
        t = stamp(($urandom_range(9) == 0) ? $urandom_range(16383) : $urandom_range(1, 9999),
                  $urandom_range(1, 12), $urandom_range(1, 31), $urandom_range(23),
                  $urandom_range(59), $urandom_range(59), $urandom_range(999999999));
        if ($urandom_range(99) < 20)
        begin
            case ($urandom_range(7))
                0: t.month        = 8'($urandom);
                1: t.day_of_month = 8'($urandom);
                2: t.hour         = 8'($urandom);
                3: t.minute       = 8'($urandom);
                4: t.second       = 8'($urandom);
                5: t.nanoseconds  = $urandom;
                6: t.year         = YEAR_W'($urandom);
                default:
                begin
                    noise = {$urandom, $urandom, $urandom};
                    t     = noise[$bits(cttc_in_t)-1:0];
                end
            endcase
        end
        return t;
    endfunction

    task automatic send_date(input cttc_in_t t);
        while (allow_gaps && $urandom_range(99) < 8)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
    endtask

    // Hold off the sender until every pending result has come back.
    task automatic drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Epoch, proleptic year zero and the top of the year range.
        send_date(stamp(1, 1, 1, 0, 0, 0, 0));
        send_date(stamp(0, 1, 1, 0, 0, 0, 0));
        send_date(stamp(0, 3, 1, 12, 30, 30, 5));
        send_date(stamp(16383, 12, 31, 23, 59, 59, 999999999));
        send_date(stamp(9999, 12, 31, 23, 59, 59, 999999999));
        // Leap day under the four, hundred and four-hundred year rules.
        send_date(stamp(2000, 2, 29, 1, 2, 3, 4));
        send_date(stamp(1900, 2, 29, 0, 0, 0, 0));
        send_date(stamp(2024, 2, 29, 0, 0, 0, 0));
        send_date(stamp(2023, 2, 29, 0, 0, 0, 0));
        send_date(stamp(2023, 2, 28, 23, 59, 59, 0));
        send_date(stamp(2000, 3, 1, 0, 0, 0, 0));
        // Out-of-range month and day.
        send_date(stamp(2020, 0, 1, 0, 0, 0, 0));
        send_date(stamp(2020, 13, 1, 0, 0, 0, 0));
        send_date(stamp(2020, 255, 255, 0, 0, 0, 0));
        send_date(stamp(2020, 5, 0, 0, 0, 0, 0));
        send_date(stamp(2020, 4, 31, 0, 0, 0, 0));
        // Out-of-range time of day and nanoseconds.
        send_date(stamp(2020, 6, 15, 24, 0, 0, 0));
        send_date(stamp(2020, 6, 15, 0, 60, 0, 0));
        send_date(stamp(2020, 6, 15, 0, 0, 60, 0));
        send_date(stamp(2020, 6, 15, 255, 255, 255, 0));
        send_date(stamp(2020, 6, 15, 0, 0, 0, 1000000000));
        send_date(stamp(2020, 6, 15, 0, 0, 0, 32'hFFFF_FFFF));
        // Sub-10 ns remainders are truncated.
        send_date(stamp(2020, 6, 15, 0, 0, 0, 9));
        send_date(stamp(2020, 6, 15, 0, 0, 0, 19));
        drain();

        for (int i = 0; i < RANDOM_DATES; i++)
        begin
            allow_gaps = !(i >= 200 && i < 360);
            if (i == 400)
                drain();
            send_date(random_date());
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        $display("Sent %0d timestamps: %0d valid dates, %0d rejected for a bad field.",
                 sent, dates_ok, dates_rejected);
        $display("Years 0 to 16383 with leap and century rules, count wrap and idle gaps.");
        if (mismatches == 0)
            $display("[calendar_to_tick_count_core] OK");
        else
            $display("[calendar_to_tick_count_core] ERROR");
        $finish;
    end

endmodule
